@@ hdl/osnp_pkg.sv @@
// shared types and constants of the oldest served node picker
package osnp_pkg;

   // default table size
   localparam int SLOT_COUNT_DEF = 64;

   // reference count limit
   localparam logic [15:0] REFS_MAX = 16'hFFFF;

   // opcodes
   localparam logic [1:0] OP_ADD    = 2'd0;
   localparam logic [1:0] OP_REMOVE = 2'd1;
   localparam logic [1:0] OP_CHOOSE = 2'd2;

   // request item
   typedef struct packed {
      logic [1:0]  opcode;
      logic [7:0]  node_index;
      logic [31:0] start_bound;
      logic [31:0] now_time;
   } req_type;

   // response item
   typedef struct packed {
      logic       found;
      logic [7:0] chosen_index;
   } rsp_type;

   // one slot of the table
   typedef struct packed {
      logic        present;
      logic [15:0] refs;
      logic [31:0] last_served;
   } slot_type;

   localparam int SLOT_W = $bits(slot_type);

endpackage

@@ hdl/osnp_ram.sv @@
// generic single write port ram with registered read
module osnp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hdl/oldest_served_node_picker_unit.sv @@
// top level of the oldest served node picker
//
// Keeps a table of node slots (present flag, reference count, last served
// time) in one ram. Request items carry an opcode: add reference, remove
// reference or choose node. Every request item gives exactly one response
// item with found and chosen_index.
//
// The unit works on one item at a time. Add and remove read the slot and
// then write it back in a read-modify-write step before the response.
// Choose walks the whole table through the single ram read port, one slot
// a cycle with one comparator, and stamps the winner on the last step.
// An add or remove with an out-of-range slot id, or an unused opcode,
// answers with found low.
//
// req_stall is high while an item is in work. The response sits in an
// output register; a new request is taken while it waits. If rsp_stall
// holds that register, the next finished item waits until it is free.
// Reset clears the slot valid bits, so every slot reads as free, and
// drops any pending response.
module oldest_served_node_picker_unit #(
   parameter int SLOT_COUNT = osnp_pkg::SLOT_COUNT_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  osnp_pkg::req_type req_item,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output osnp_pkg::rsp_type rsp_item
);

   import osnp_pkg::*;

   localparam int IDX_W = $clog2(SLOT_COUNT);
   localparam logic [8:0] SLOT_LIMIT = 9'(SLOT_COUNT);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SLOT_COUNT - 1);

   // state codes
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_MOD  = 2'd1;
   localparam logic [1:0] S_SCAN = 2'd2;
   localparam logic [1:0] S_DONE = 2'd3;

   logic [1:0]            state_ff, state_in;
   logic [1:0]            op_ff, op_in;
   logic [IDX_W-1:0]      idx_ff, idx_in;
   logic [31:0]           start_ff, start_in;
   logic [31:0]           now_ff, now_in;
   logic [IDX_W-1:0]      scan_ff, scan_in;
   logic                  have_ff, have_in;
   logic [IDX_W-1:0]      best_ff, best_in;
   logic [31:0]           best_time_ff, best_time_in;
   // refs of the current best, kept so the stamp rewrites the whole slot
   logic [15:0]           best_refs_ff, best_refs_in;
   logic                  res_found_ff, res_found_in;
   logic [IDX_W-1:0]      res_idx_ff, res_idx_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_type               rsp_ff, rsp_in;
   logic [SLOT_COUNT-1:0] valid_ff, valid_in;

   logic                  accept;
   logic                  in_range;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [SLOT_W-1:0]     rd_raw;
   slot_type              cur;
   logic [IDX_W-1:0]      cur_idx;
   logic                  cur_present;
   logic                  wr_en;
   logic [IDX_W-1:0]      wr_addr;
   slot_type              wr_slot;
   logic                  eligible;
   logic                  take;
   logic                  rsp_load;

   // slot table
   osnp_ram #(
      .WIDTH (SLOT_W),
      .DEPTH (SLOT_COUNT)
   ) u_slot_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_slot),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_raw)
   );

   assign accept    = req_valid && !req_stall;
   assign req_stall = (state_ff != S_IDLE);
   assign in_range  = ({1'b0, req_item.node_index} < SLOT_LIMIT);

   // slot read back, never-written entries count as free
   assign cur         = slot_type'(rd_raw);
   assign cur_idx     = (state_ff == S_SCAN) ? scan_ff : idx_ff;
   assign cur_present = valid_ff[cur_idx] && cur.present;

   // scan compare
   assign eligible = cur_present && (cur.last_served <= start_ff);
   assign take     = eligible && (!have_ff || (cur.last_served < best_time_ff));

   assign rsp_load = (state_ff == S_DONE) && (!rsp_valid_ff || !rsp_stall);

   // read address and enable
   always_comb begin
      rd_en   = 1'b0;
      rd_addr = '0;
      if (state_ff == S_IDLE) begin
         rd_en = accept;
         if (req_item.opcode == OP_CHOOSE) begin
            rd_addr = '0;
         end else begin
            rd_addr = req_item.node_index[IDX_W-1:0];
         end
      end else if (state_ff == S_SCAN) begin
         rd_en   = (scan_ff != LAST_IDX);
         rd_addr = scan_ff + 1'b1;
      end
   end

   // read-modify-write of a slot and the stamp at the end of a scan
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = idx_ff;
      wr_slot = cur;
      wr_slot.present = cur_present;
      if (state_ff == S_MOD) begin
         wr_en = 1'b1;
         if (op_ff == OP_ADD) begin
            if (cur_present) begin
               if (cur.refs != REFS_MAX) begin
                  wr_slot.refs = cur.refs + 16'd1;
               end
            end else begin
               wr_slot.present     = 1'b1;
               wr_slot.refs        = 16'd1;
               wr_slot.last_served = '0;
            end
         end else if (cur_present) begin
            if (cur.refs != 16'd0) begin
               wr_slot.refs = cur.refs - 16'd1;
            end
            if (cur.refs <= 16'd1) begin
               wr_slot.present     = 1'b0;
               wr_slot.refs        = '0;
               wr_slot.last_served = '0;
            end
         end
      end else if (state_ff == S_SCAN && scan_ff == LAST_IDX) begin
         // stamp the winner; its refs come from the scan ram read
         wr_en   = take || have_ff;
         wr_addr = take ? scan_ff : best_ff;
         wr_slot.present     = 1'b1;
         wr_slot.last_served = now_ff;
         if (!take) begin
            wr_slot.refs = best_refs_ff;
         end
      end
   end

   // control and datapath next state
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      idx_in       = idx_ff;
      start_in     = start_ff;
      now_in       = now_ff;
      scan_in      = scan_ff;
      have_in      = have_ff;
      best_in      = best_ff;
      best_time_in = best_time_ff;
      best_refs_in = best_refs_ff;
      res_found_in = res_found_ff;
      res_idx_in   = res_idx_ff;
      valid_in     = valid_ff;

      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in        = req_item.opcode;
               idx_in       = req_item.node_index[IDX_W-1:0];
               start_in     = req_item.start_bound;
               now_in       = req_item.now_time;
               scan_in      = '0;
               have_in      = 1'b0;
               res_found_in = 1'b0;
               res_idx_in   = '0;
               if (req_item.opcode == OP_CHOOSE) begin
                  state_in = S_SCAN;
               end else if ((req_item.opcode inside {OP_ADD, OP_REMOVE}) && in_range) begin
                  state_in = S_MOD;
               end else begin
                  state_in = S_DONE;
               end
            end
         end
         S_MOD: begin
            state_in = S_DONE;
         end
         S_SCAN: begin
            if (take) begin
               have_in      = 1'b1;
               best_in      = scan_ff;
               best_time_in = cur.last_served;
               best_refs_in = cur.refs;
            end
            if (scan_ff == LAST_IDX) begin
               res_found_in = take || have_ff;
               res_idx_in   = take ? scan_ff : (have_ff ? best_ff : '0);
               state_in     = S_DONE;
            end else begin
               scan_in = scan_ff + 1'b1;
            end
         end
         S_DONE: begin
            if (rsp_load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (wr_en) begin
         valid_in[wr_addr] = 1'b1;
      end
   end

   // response register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (rsp_load) begin
         rsp_valid_in        = 1'b1;
         rsp_in.found        = res_found_ff;
         rsp_in.chosen_index = 8'(res_idx_ff);
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         valid_ff     <= valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      idx_ff       <= idx_in;
      start_ff     <= start_in;
      now_ff       <= now_in;
      scan_ff      <= scan_in;
      have_ff      <= have_in;
      best_ff      <= best_in;
      best_time_ff <= best_time_in;
      best_refs_ff <= best_refs_in;
      res_found_ff <= res_found_in;
      res_idx_ff   <= res_idx_in;
      rsp_ff       <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

   // table writes only come from the update or the scan stamp
   a_write_state: assert property (@(posedge clock) disable iff (reset)
      wr_en |-> (state_ff == S_MOD || state_ff == S_SCAN))
      else $error("slot write outside update or scan");

   // an accepted item makes the unit busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff != S_IDLE))
      else $error("accepted item did not start work");

   // only a choose can report a found slot
   a_found_choose: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DONE && res_found_ff) |-> (op_ff == OP_CHOOSE))
      else $error("found set for a non-choose item");

   // a found slot lies inside the table
   a_found_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.found) |-> ({1'b0, rsp_ff.chosen_index} < SLOT_LIMIT))
      else $error("chosen slot outside the table");

   // a miss reports slot zero
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.found) |-> (rsp_ff.chosen_index == 8'd0))
      else $error("miss with nonzero chosen index");

endmodule

@@ tb/sv/oldest_served_node_picker_unit_test.sv @@
// testbench of the oldest served node picker checked against a slot table predictor
module oldest_served_node_picker_unit_test;
   import osnp_pkg::*;

   localparam int SLOTS         = SLOT_COUNT_DEF;
   localparam int HALF_PERIOD   = 6;
   localparam int RESET_CYCLES  = 12;
   localparam int STALL_LIMIT   = 4000;
   localparam int SETTLE_CYCLES = SLOTS + 20;
   localparam int RANDOM_ITEMS  = 1600;
   localparam int QUIET_TAIL    = 200;
   localparam int DRAIN_EVERY   = 400;
   localparam int REPEAT_ADDS   = 8;
   localparam int TOP_SLOT      = SLOTS - 1;
   localparam logic [1:0]  OP_UNUSED = 2'd3;
   localparam logic [31:0] TIME_MAX  = 32'hFFFF_FFFF;

   // one item waiting to be sent
   typedef struct {
      req_type item;
      bit      drain_first;
      bit      calm;
   } pending_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_item = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_item;

   pending_type pending[$];
   rsp_type     expected_rsp[$];

   // predictor copy of the slot table
   logic        tbl_present [0:SLOTS-1];
   logic [15:0] tbl_refs    [0:SLOTS-1];
   logic [31:0] tbl_served  [0:SLOTS-1];

   int n_adds, n_removes, n_picked, n_none, n_ignored;
   int n_checked, mismatch_count, quiet_cycles;
   int send_gap, stall_gap;
   bit send_gaps_on = 1'b1;
   bit stall_gaps_on = 1'b1;
   bit tail_phase;

   oldest_served_node_picker_unit #(
      .SLOT_COUNT(SLOTS)
   ) u_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_item  (rsp_item)
   );

   always #HALF_PERIOD clock = ~clock;

   initial begin
      for (int i = 0; i < SLOTS; i++) begin
         tbl_present[i] = 1'b0;
         tbl_refs[i]    = '0;
         tbl_served[i]  = '0;
      end
   end

   // apply one item to the slot table and return the response it gives
   function automatic rsp_type pick_oldest_served(input req_type r);
      rsp_type     res;
      int          id;
      int          best;
      logic [31:0] best_served;
      res         = '0;
      id          = r.node_index;
      best        = -1;
      best_served = '0;
      case (r.opcode)
         OP_ADD: begin
            if (id < SLOTS) begin
               n_adds++;
               if (tbl_present[id]) begin
                  if (tbl_refs[id] != REFS_MAX)
                     tbl_refs[id] = tbl_refs[id] + 16'd1;
               end else begin
                  tbl_present[id] = 1'b1;
                  tbl_refs[id]    = 16'd1;
                  tbl_served[id]  = '0;
               end
            end else begin
               n_ignored++;
            end
         end
         OP_REMOVE: begin
            if (id < SLOTS) begin
               n_removes++;
               if (tbl_present[id]) begin
                  if (tbl_refs[id] != 16'd0)
                     tbl_refs[id] = tbl_refs[id] - 16'd1;
                  if (tbl_refs[id] == 16'd0) begin
                     tbl_present[id] = 1'b0;
                     tbl_served[id]  = '0;
                  end
               end
            end else begin
               n_ignored++;
            end
         end
         OP_CHOOSE: begin
            // oldest eligible slot, lowest id on a tie
            for (int i = 0; i < SLOTS; i++) begin
               if (tbl_present[i] && tbl_served[i] <= r.start_bound &&
                   (best < 0 || tbl_served[i] < best_served)) begin
                  best        = i;
                  best_served = tbl_served[i];
               end
            end
            if (best >= 0) begin
               tbl_served[best] = r.now_time;
               res.found        = 1'b1;
               res.chosen_index = best[7:0];
               n_picked++;
            end else begin
               n_none++;
            end
         end
         default: n_ignored++;
      endcase
      return res;
   endfunction

   function automatic req_type make_req(input logic [1:0] op, input logic [7:0] idx,
                                        input logic [31:0] st, input logic [31:0] nw);
      req_type r;
      r.opcode      = op;
      r.node_index  = idx;
      r.start_bound = st;
      r.now_time    = nw;
      return r;
   endfunction

   task automatic enqueue(input req_type r, input bit drain, input bit calm);
      pending_type p;
      p.item        = r;
      p.drain_first = drain;
      p.calm        = calm;
      pending.insert(pending.size(), p);
   endtask

   task automatic note_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("mismatch on response %0d: %s expected %0h got %0h",
                  n_checked, what, want, got);
   endtask

   // request driver: holds an item until taken, idles in bursts
   always @(posedge clock) begin : drive
      if (reset) begin
         req_valid  <= 1'b0;
         req_item   <= '0;
         send_gap   <= 0;
         tail_phase <= 1'b0;
      end else begin
         if (req_valid && !req_stall)
            expected_rsp.insert(expected_rsp.size(), pick_oldest_served(req_item));
         if ($urandom_range(0, 299) == 0)
            send_gaps_on <= !send_gaps_on;
         tail_phase <= (pending.size() == 0) || pending[0].calm;
         if (!req_valid || !req_stall) begin
            if (send_gap > 0) begin
               send_gap  <= send_gap - 1;
               req_valid <= 1'b0;
            end else if (pending.size() == 0) begin
               req_valid <= 1'b0;
            end else if (pending[0].drain_first && expected_rsp.size() != 0) begin
               // hold off until every response is back
               req_valid <= 1'b0;
            end else if (!pending[0].calm && send_gaps_on && $urandom_range(0, 9) == 0) begin
               req_valid <= 1'b0;
               send_gap  <= $urandom_range(0, 4);
            end else begin
               req_item  <= pending[0].item;
               req_valid <= 1'b1;
               pending.pop_front();
            end
         end
      end
   end

   // response monitor: checks each item and stalls in bursts
   always @(posedge clock) begin : observe
      rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_gap <= 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            n_checked++;
            if (expected_rsp.size() == 0) begin
               note_mismatch("item with nothing pending", '0, {23'd0, rsp_item});
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_item.found !== want.found)
                  note_mismatch("found", 32'(want.found), 32'(rsp_item.found));
               if (rsp_item.chosen_index !== want.chosen_index)
                  note_mismatch("chosen_index", 32'(want.chosen_index),
                                32'(rsp_item.chosen_index));
            end
         end
         if ($urandom_range(0, 299) == 0)
            stall_gaps_on <= !stall_gaps_on;
         if (stall_gap > 0) begin
            stall_gap <= stall_gap - 1;
            rsp_stall <= 1'b1;
         end else if (!tail_phase && stall_gaps_on && $urandom_range(0, 7) == 0) begin
            stall_gap <= $urandom_range(0, 4);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // watchdog on cycles with no handshake on either side
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("no item moved for %0d cycles, %0d responses outstanding",
                  quiet_cycles, expected_rsp.size());
         $display("FAIL");
         $finish;
      end
   end

   // stimulus and end of run
   initial begin
      req_type     r;
      int          counted;
      int          kind;
      logic [31:0] sim_now;
      logic [31:0] recent_now [0:7];
      bit          drain;

      for (int i = 0; i < 8; i++)
         recent_now[i] = '0;

      // directed: empty table, out of range ids, ties, time bounds, frees
      enqueue(make_req(OP_CHOOSE, 8'd0, TIME_MAX, 32'd7), 1'b0, 1'b0);
      enqueue(make_req(OP_REMOVE, 8'd3, '0, '0), 1'b0, 1'b0);
      enqueue(make_req(OP_ADD, 8'd0, '0, '0), 1'b0, 1'b0);
      enqueue(make_req(OP_ADD, 8'd1, '0, '0), 1'b0, 1'b0);
      enqueue(make_req(OP_ADD, TOP_SLOT[7:0], '0, '0), 1'b0, 1'b0);
      enqueue(make_req(OP_ADD, SLOTS[7:0], TIME_MAX, TIME_MAX), 1'b0, 1'b0);
      enqueue(make_req(OP_ADD, 8'd255, TIME_MAX, TIME_MAX), 1'b0, 1'b0);
      enqueue(make_req(OP_REMOVE, 8'd128, '0, '0), 1'b0, 1'b0);
      enqueue(make_req(OP_CHOOSE, 8'd255, 32'd0, 32'd100), 1'b0, 1'b0);
      enqueue(make_req(OP_CHOOSE, 8'd0, 32'd0, 32'd200), 1'b0, 1'b0);
      enqueue(make_req(OP_CHOOSE, 8'd0, 32'd99, 32'd300), 1'b0, 1'b0);
      enqueue(make_req(OP_CHOOSE, 8'd0, 32'd99, 32'd400), 1'b0, 1'b0);
      enqueue(make_req(OP_CHOOSE, 8'd0, 32'd100, TIME_MAX), 1'b0, 1'b0);
      enqueue(make_req(OP_CHOOSE, 8'd0, TIME_MAX, 32'd0), 1'b0, 1'b0);
      enqueue(make_req(OP_ADD, 8'd1, '0, '0), 1'b0, 1'b0);
      enqueue(make_req(OP_REMOVE, 8'd1, '0, '0), 1'b0, 1'b0);
      enqueue(make_req(OP_REMOVE, 8'd1, '0, '0), 1'b0, 1'b0);
      enqueue(make_req(OP_CHOOSE, 8'd0, TIME_MAX, 32'd5), 1'b0, 1'b0);
      enqueue(make_req(OP_UNUSED, 8'd255, TIME_MAX, TIME_MAX), 1'b0, 1'b0);
      enqueue(make_req(OP_REMOVE, 8'd0, '0, '0), 1'b0, 1'b0);
      enqueue(make_req(OP_REMOVE, TOP_SLOT[7:0], '0, '0), 1'b0, 1'b0);
      enqueue(make_req(OP_CHOOSE, 8'd0, TIME_MAX, 32'd9), 1'b0, 1'b0);

      // random traffic, mostly in-range slots with rising timestamps
      counted = 0;
      sim_now = $urandom_range(1000, 5000);
      drain   = 1'b1;
      while (counted < RANDOM_ITEMS) begin
         r.opcode      = OP_UNUSED;
         r.node_index  = 8'($urandom_range(0, 255));
         r.start_bound = $urandom;
         r.now_time    = $urandom;
         kind = $urandom_range(0, 99);
         if (kind < 50) begin
            r.opcode     = (kind < 27) ? OP_ADD : OP_REMOVE;
            r.node_index = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, SLOTS - 1))
                                                       : 8'($urandom_range(0, 11));
         end else if (kind < 90) begin
            r.opcode = OP_CHOOSE;
            sim_now  = sim_now + $urandom_range(1, 5000);
            if ($urandom_range(0, 19) != 0)
               r.now_time = sim_now;
            case ($urandom_range(0, 4))
               0: r.start_bound = TIME_MAX;
               1: r.start_bound = recent_now[$urandom_range(0, 7)];
               2: r.start_bound = recent_now[$urandom_range(0, 7)] - 32'd1;
               3: r.start_bound = 32'd0;
               default: ;
            endcase
            recent_now[$urandom_range(0, 7)] = r.now_time;
         end else if (kind < 95) begin
            r.opcode     = $urandom_range(0, 1) ? OP_ADD : OP_REMOVE;
            r.node_index = 8'($urandom_range(SLOTS, 255));
         end
         enqueue(r, drain, counted >= RANDOM_ITEMS - QUIET_TAIL);
         drain = 1'b0;
         counted++;
         if (counted % DRAIN_EVERY == 0)
            drain = 1'b1;
      end

      // repeated adds and removes on the top slot, then sweep every present slot
      for (int i = 0; i < REPEAT_ADDS; i++)
         enqueue(make_req(OP_ADD, TOP_SLOT[7:0], '0, '0), i == 0, 1'b1);
      for (int i = 0; i < 3; i++)
         enqueue(make_req(OP_REMOVE, TOP_SLOT[7:0], '0, '0), 1'b0, 1'b1);
      for (int i = 0; i < SLOTS + 6; i++) begin
         sim_now = sim_now + 32'd1;
         enqueue(make_req(OP_CHOOSE, 8'd0, TIME_MAX, sim_now), 1'b0, 1'b1);
      end

      // release reset after the hold time
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // wait for every item to be sent and answered
      @(negedge clock);
      while (pending.size() != 0 || req_valid || expected_rsp.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (expected_rsp.size() != 0)
         note_mismatch("responses never returned", '0, expected_rsp.size());

      $display("covered %0d adds, %0d removes, %0d chooses with a pick, %0d with none",
               n_adds, n_removes, n_picked, n_none);
      $display("plus %0d ignored items; %0d responses checked, %0d mismatches",
               n_ignored, n_checked, mismatch_count);
      if (mismatch_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

@@ oldest_served_node_picker_unit.f @@
hdl/osnp_pkg.sv
hdl/osnp_ram.sv
hdl/oldest_served_node_picker_unit.sv
tb/sv/oldest_served_node_picker_unit_test.sv
